[rtl/rll_pkg.sv]
package rll_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_W    = 12;
    localparam int LADDER_N  = 4;
    localparam int LAD_W     = $clog2(LADDER_N);

    localparam int C_W       = 12;
    localparam int W_W       = 13;
    localparam int P_W       = 13;
    localparam int T_W       = 14;
    localparam int TT_W      = 13;
    localparam int T2_W      = 17;
    localparam int T3_W      = 19;
    localparam int SUM_W     = 17;
    localparam int NUM_W     = SUM_W + FRAC_W;
    localparam int DIV_Q_W   = 15;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);
    localparam int R_W       = 15;
    localparam int CTR_W     = SAMPLE_W + 2;

    localparam int ONE_Q12       = 4096;
    localparam int FULL_SCALE    = 4095;
    localparam int CUT_SCALE     = 9;
    localparam int RECIP10       = 52429;
    localparam int RECIP10_SHIFT = 19;
    localparam int CUT_RECIP     = CUT_SCALE * RECIP10;
    localparam int P_POLY_A      = 7373;
    localparam int P_POLY_B      = 3277;
    localparam int T_COEF        = 5678;
    localparam int T2_BASE       = 49152;
    localparam int T3_COEF       = 24576;
    localparam int T3_MUL        = T3_COEF / ONE_Q12;
    localparam int CLIP_COEF     = 683;
    localparam int OUT_MAX       = 2 * (1 << SAMPLE_W) - 1;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_C,
        MUL_U,
        MUL_P,
        MUL_T,
        MUL_TT,
        MUL_R,
        MUL_X,
        MUL_LAD_IN,
        MUL_LAD_PREV,
        MUL_LAD_FB,
        MUL_A,
        MUL_B,
        MUL_CLIP
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_C,
        WB_W,
        WB_P,
        WB_T,
        WB_T2,
        WB_R,
        WB_X,
        WB_Y,
        WB_A,
        WB_B,
        WB_CLIP
    } wb_t;

    typedef struct packed {
        mul_sel_t               mul_sel;
        acc_op_t                acc_op;
        wb_t                    wb;
        logic [LAD_W-1:0]       lad_idx;
        logic                   in_load;
        logic                   div_start;
        logic                   commit;
    } rll_cmd_t;

    typedef struct packed {
        logic div_done;
    } rll_stat_t;

endpackage

[rtl/rll_in_if.sv]
interface rll_in_if import rll_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] audio_sample;
    logic [SAMPLE_W-1:0] cutoff;
    logic [SAMPLE_W-1:0] resonance;

    modport source (output valid, output audio_sample, output cutoff, output resonance,
                    input ready);
    modport sink   (input valid, input audio_sample, input cutoff, input resonance,
                    output ready);

endinterface

[rtl/rll_out_if.sv]
interface rll_out_if import rll_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);

endinterface

[rtl/rll_div.sv]
module rll_div import rll_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [SUM_W-1:0]   divisor,
    output logic [DIV_Q_W-1:0] quotient,
    output logic               done
);

    logic [NUM_W-1:0]     num;
    logic [SUM_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     den_reg;
    logic [DIV_Q_W-1:0]   bits_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SUM_W:0]       trial;
    logic                 fits;
    logic [SUM_W:0]       trial_sub;

    assign num       = {dividend, {FRAC_W{1'b0}}};
    assign trial     = {rem_reg, bits_reg[DIV_Q_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_Q_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= SUM_W'(num >> DIV_Q_W);
            bits_reg <= num[DIV_Q_W-1:0];
            den_reg  <= divisor;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            bits_reg <= {bits_reg[DIV_Q_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[DIV_Q_W-2:0], fits};
            rem_reg  <= fits ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("division started while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("division did not begin");

    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished division");

endmodule

[rtl/rll_datapath.sv]
module rll_datapath import rll_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rll_cmd_t            cmd,
    output rll_stat_t           stat,
    input  logic [SAMPLE_W-1:0] audio_sample,
    input  logic [SAMPLE_W-1:0] cutoff,
    input  logic [SAMPLE_W-1:0] resonance,
    output logic [SAMPLE_W-1:0] filtered_sample
);

    logic [SAMPLE_W-1:0]      s_reg;
    logic [SAMPLE_W-1:0]      cut_reg;
    logic [SAMPLE_W-1:0]      res_reg;
    logic [C_W-1:0]           c_reg;
    logic [W_W-1:0]           w_reg;
    logic [P_W-1:0]           p_reg;
    logic signed [T_W-1:0]    t_reg;
    logic [T2_W-1:0]          t2_reg;
    logic [R_W-1:0]           r_reg;
    logic signed [WORD_W-1:0] x_reg;
    logic signed [WORD_W-1:0] y4_reg;
    logic signed [WORD_W-1:0] a_reg;
    logic signed [WORD_W-1:0] b_reg;
    logic [SAMPLE_W-1:0]      out_reg;

    logic signed [WORD_W-1:0] stage_reg [LADDER_N];
    logic signed [WORD_W-1:0] prev_x_reg;
    logic signed [WORD_W-1:0] prev_stage_reg [LADDER_N-1];

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic signed [WORD_W-1:0] q_val;

    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic [LAD_W-1:0]         idx_m1;
    logic signed [P_W+1:0]    k_val;
    logic signed [T_W-1:0]    pm_val;
    logic signed [T3_W-1:0]   t3_val;
    logic signed [T3_W-1:0]   sum_val;
    logic signed [T3_W-1:0]   diff_val;
    logic signed [CTR_W-1:0]  ctr_val;
    logic signed [WORD_W:0]   o_sum;
    logic [SAMPLE_W:0]        o_clamp;
    logic [DIV_Q_W-1:0]       g_val;
    logic                     div_done;

    assign idx_m1   = cmd.lad_idx - 1'b1;
    assign k_val    = $signed({1'b0, p_reg, 1'b0}) - (P_W+2)'(FULL_SCALE);
    assign pm_val   = T_W'(ONE_Q12) - $signed({1'b0, p_reg});
    assign t3_val   = T3_W'(t_reg) * T3_W'(T3_MUL);
    assign sum_val  = $signed({2'b0, t2_reg}) + t3_val;
    assign diff_val = $signed({2'b0, t2_reg}) - t3_val;
    assign ctr_val  = $signed({1'b0, s_reg, 1'b0}) - CTR_W'(ONE_Q12);

    rll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_val[SUM_W-1:0]),
        .divisor  (diff_val[SUM_W-1:0]),
        .quotient (g_val),
        .done     (div_done)
    );

    assign stat.div_done = div_done;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_C:
            begin
                mul_a = WORD_W'(cut_reg);
                mul_b = WORD_W'(CUT_RECIP);
            end
            MUL_U:
            begin
                mul_a = WORD_W'(c_reg);
                mul_b = WORD_W'(P_POLY_B);
            end
            MUL_P:
            begin
                mul_a = WORD_W'(c_reg);
                mul_b = WORD_W'(w_reg);
            end
            MUL_T:
            begin
                mul_a = WORD_W'(pm_val);
                mul_b = WORD_W'(T_COEF);
            end
            MUL_TT:
            begin
                mul_a = WORD_W'(t_reg);
                mul_b = WORD_W'(t_reg);
            end
            MUL_R:
            begin
                mul_a = WORD_W'(res_reg);
                mul_b = WORD_W'(g_val);
            end
            MUL_X:
            begin
                mul_a = WORD_W'(r_reg);
                mul_b = stage_reg[LADDER_N-1];
            end
            MUL_LAD_IN:
            begin
                if (cmd.lad_idx == '0)
                begin
                    mul_a = x_reg;
                end
                else
                begin
                    mul_a = stage_reg[idx_m1];
                end
                mul_b = WORD_W'(p_reg);
            end
            MUL_LAD_PREV:
            begin
                if (cmd.lad_idx == '0)
                begin
                    mul_a = prev_x_reg;
                end
                else
                begin
                    mul_a = prev_stage_reg[idx_m1];
                end
                mul_b = WORD_W'(p_reg);
            end
            MUL_LAD_FB:
            begin
                mul_a = WORD_W'(k_val);
                mul_b = stage_reg[cmd.lad_idx];
            end
            MUL_A:
            begin
                mul_a = y4_reg;
                mul_b = WORD_W'(CLIP_COEF);
            end
            MUL_B:
            begin
                mul_a = y4_reg;
                mul_b = a_reg;
            end
            MUL_CLIP:
            begin
                mul_a = y4_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    assign q_val = acc_next[FRAC_W +: WORD_W];

    always_comb
    begin
        o_sum = {stage_reg[LADDER_N-1][WORD_W-1], stage_reg[LADDER_N-1]}
              + (WORD_W+1)'(ONE_Q12);
        if (o_sum < 0)
        begin
            o_clamp = '0;
        end
        else if (o_sum > (WORD_W+1)'(OUT_MAX))
        begin
            o_clamp = (SAMPLE_W+1)'(OUT_MAX);
        end
        else
        begin
            o_clamp = o_sum[SAMPLE_W:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.acc_op != ACC_NONE)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.in_load)
        begin
            s_reg   <= audio_sample;
            cut_reg <= cutoff;
            res_reg <= resonance;
        end
        case (cmd.wb)
            WB_C:  c_reg  <= acc_next[RECIP10_SHIFT +: C_W];
            WB_W:  w_reg  <= W_W'(P_POLY_A) - acc_next[FRAC_W +: W_W];
            WB_P:  p_reg  <= acc_next[FRAC_W +: P_W];
            WB_T:  t_reg  <= acc_next[FRAC_W +: T_W];
            WB_T2: t2_reg <= T2_W'(T2_BASE) + T2_W'(acc_next[FRAC_W +: TT_W]);
            WB_R:  r_reg  <= acc_next[FRAC_W +: R_W];
            WB_X:  x_reg  <= WORD_W'(ctr_val) - q_val;
            WB_Y:
            begin
                if (cmd.lad_idx == LAD_W'(LADDER_N - 1))
                begin
                    y4_reg <= q_val;
                end
            end
            WB_A:  a_reg  <= q_val;
            WB_B:  b_reg  <= q_val;
            default:
            begin
            end
        endcase
        if (cmd.commit)
        begin
            out_reg <= o_clamp[SAMPLE_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LADDER_N; i++)
            begin
                stage_reg[i] <= '0;
            end
            for (int i = 0; i < LADDER_N - 1; i++)
            begin
                prev_stage_reg[i] <= '0;
            end
            prev_x_reg <= '0;
        end
        else
        begin
            if (cmd.wb == WB_Y && cmd.lad_idx != LAD_W'(LADDER_N - 1))
            begin
                stage_reg[cmd.lad_idx] <= q_val;
            end
            if (cmd.wb == WB_CLIP)
            begin
                stage_reg[LADDER_N-1] <= y4_reg - q_val;
            end
            if (cmd.commit)
            begin
                prev_x_reg <= x_reg;
                for (int i = 0; i < LADDER_N - 1; i++)
                begin
                    prev_stage_reg[i] <= stage_reg[i];
                end
            end
        end
    end

    assign filtered_sample = out_reg;

endmodule

[rtl/rll_ctrl.sv]
module rll_ctrl import rll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output rll_cmd_t  cmd,
    input  rll_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_C_M,
        S_C_A,
        S_U_M,
        S_U_A,
        S_P_M,
        S_P_A,
        S_T_M,
        S_T_A,
        S_TT_M,
        S_TT_A,
        S_DIV_GO,
        S_DIV_WAIT,
        S_R_M,
        S_R_A,
        S_X_M,
        S_X_A,
        S_L_M1,
        S_L_M2,
        S_L_M3,
        S_L_A,
        S_A_M,
        S_A_A,
        S_B_M,
        S_B_A,
        S_K_M,
        S_K_A,
        S_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [LAD_W-1:0] lad_reg;
    logic [LAD_W-1:0] lad_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             commit;

    assign commit = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_NONE;
        cmd.acc_op     = ACC_NONE;
        cmd.wb         = WB_NONE;
        cmd.lad_idx    = lad_reg;
        cmd.commit     = commit;
        state_next     = state_reg;
        lad_next       = lad_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_load = in_valid;
                if (in_valid)
                begin
                    state_next = S_C_M;
                end
            end
            S_C_M:
            begin
                cmd.mul_sel = MUL_C;
                state_next  = S_C_A;
            end
            S_C_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_C;
                state_next = S_U_M;
            end
            S_U_M:
            begin
                cmd.mul_sel = MUL_U;
                state_next  = S_U_A;
            end
            S_U_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_W;
                state_next = S_P_M;
            end
            S_P_M:
            begin
                cmd.mul_sel = MUL_P;
                state_next  = S_P_A;
            end
            S_P_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_P;
                state_next = S_T_M;
            end
            S_T_M:
            begin
                cmd.mul_sel = MUL_T;
                state_next  = S_T_A;
            end
            S_T_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_T;
                state_next = S_TT_M;
            end
            S_TT_M:
            begin
                cmd.mul_sel = MUL_TT;
                state_next  = S_TT_A;
            end
            S_TT_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_T2;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_R_M;
                end
            end
            S_R_M:
            begin
                cmd.mul_sel = MUL_R;
                state_next  = S_R_A;
            end
            S_R_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_R;
                state_next = S_X_M;
            end
            S_X_M:
            begin
                cmd.mul_sel = MUL_X;
                state_next  = S_X_A;
            end
            S_X_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_X;
                lad_next   = '0;
                state_next = S_L_M1;
            end
            S_L_M1:
            begin
                cmd.mul_sel = MUL_LAD_IN;
                state_next  = S_L_M2;
            end
            S_L_M2:
            begin
                cmd.mul_sel = MUL_LAD_PREV;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_L_M3;
            end
            S_L_M3:
            begin
                cmd.mul_sel = MUL_LAD_FB;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_L_A;
            end
            S_L_A:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.wb     = WB_Y;
                lad_next   = lad_reg + 1'b1;
                if (lad_reg == LAD_W'(LADDER_N - 1))
                begin
                    state_next = S_A_M;
                end
                else
                begin
                    state_next = S_L_M1;
                end
            end
            S_A_M:
            begin
                cmd.mul_sel = MUL_A;
                state_next  = S_A_A;
            end
            S_A_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_A;
                state_next = S_B_M;
            end
            S_B_M:
            begin
                cmd.mul_sel = MUL_B;
                state_next  = S_B_A;
            end
            S_B_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_B;
                state_next = S_K_M;
            end
            S_K_M:
            begin
                cmd.mul_sel = MUL_CLIP;
                state_next  = S_K_A;
            end
            S_K_A:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.wb     = WB_CLIP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lad_reg       <= lad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_DIV_WAIT)
        else $error("division finished outside its wait state");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> state_reg == S_DONE)
        else $error("result overwritten while the output is stalled");

    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_C_M)
        else $error("accepted request did not start computation");

endmodule

[rtl/resonant_ladder_lowpass.sv]
// Requests are taken one at a time: a new request is accepted only in the idle
// state, after the last result is committed; the shared 32x32 multiplier forms
// 22 products and a 15-step restoring divider forms the gain.
// The output register holds a result while the next request is accepted.
// Reset (rst_n, asynchronous, active low) clears all filter stages and history.
module resonant_ladder_lowpass import rll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rll_in_if.sink    samples,
    rll_out_if.source results
);

    rll_cmd_t  cmd;
    rll_stat_t stat;

    rll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rll_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .audio_sample    (samples.audio_sample),
        .cutoff          (samples.cutoff),
        .resonance       (samples.resonance),
        .filtered_sample (results.filtered_sample)
    );

endmodule

[tb/sv/ladder_checker.sv]
module ladder_checker import rll_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rll_in_if    samples,
    rll_out_if   results,
    output int   mismatches,
    output int   outstanding
);

    int pole1;
    int pole2;
    int pole3;
    int pole4;
    int last_drive;
    int last_pole1;
    int last_pole2;
    int last_pole3;

    logic [SAMPLE_W-1:0] expected_out[$];

    function automatic longint q12(input longint v);
        return longint'(int'(v >>> FRAC_W));
    endfunction

    function automatic logic [SAMPLE_W-1:0] ladder_step(input logic [SAMPLE_W-1:0] s_in,
                                                        input logic [SAMPLE_W-1:0] cut_in,
                                                        input logic [SAMPLE_W-1:0] res_in);
        longint s, cut, res, c, p, k, t, t2, t3, g, r;
        longint x, y1, y2, y3, y4, a, b, o;
        s   = longint'(s_in);
        cut = longint'(cut_in);
        res = longint'(res_in);

        c  = (cut * CUT_SCALE) / 10;
        p  = (c * (P_POLY_A - ((P_POLY_B * c) >>> FRAC_W))) >>> FRAC_W;
        k  = p + p - FULL_SCALE;
        t  = ((ONE_Q12 - p) * T_COEF) >>> FRAC_W;
        t2 = T2_BASE + ((t * t) >>> FRAC_W);
        t3 = (T3_COEF * t) >>> FRAC_W;
        if (t2 - t3 > 0 && t2 + t3 >= 0)
            g = (ONE_Q12 * (t2 + t3)) / (t2 - t3);
        else
            g = 0;
        r = (res * g) >>> FRAC_W;

        x  = longint'(int'((s * 2 - ONE_Q12) - q12(r * longint'(pole4))));
        y1 = q12(x * p + longint'(last_drive) * p - k * longint'(pole1));
        y2 = q12(y1 * p + longint'(last_pole1) * p - k * longint'(pole2));
        y3 = q12(y2 * p + longint'(last_pole2) * p - k * longint'(pole3));
        y4 = q12(y3 * p + longint'(last_pole3) * p - k * longint'(pole4));

        // soft clip: y - y^3/6
        a  = q12(y4 * CLIP_COEF);
        b  = q12(y4 * a);
        y4 = longint'(int'(y4 - q12(y4 * b)));

        pole1      = int'(y1);
        pole2      = int'(y2);
        pole3      = int'(y3);
        pole4      = int'(y4);
        last_drive = int'(x);
        last_pole1 = int'(y1);
        last_pole2 = int'(y2);
        last_pole3 = int'(y3);

        o = y4 + ONE_Q12;
        if (o < 0)
            o = 0;
        if (o > OUT_MAX)
            o = OUT_MAX;
        return o[SAMPLE_W:1];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [SAMPLE_W-1:0] want;
        if (!rst_n)
        begin
            pole1       = 0;
            pole2       = 0;
            pole3       = 0;
            pole4       = 0;
            last_drive  = 0;
            last_pole1  = 0;
            last_pole2  = 0;
            last_pole3  = 0;
            mismatches  = 0;
            outstanding = 0;
            expected_out.delete();
        end
        else
        begin
            if (results.valid === 1'b1 && results.ready === 1'b1)
            begin
                if (expected_out.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result %0d", results.filtered_sample);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (want !== results.filtered_sample)
                    begin
                        if (mismatches < 10)
                            $display("filtered_sample mismatch: expected %0d got %0d",
                                     want, results.filtered_sample);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (samples.valid === 1'b1 && samples.ready === 1'b1)
                expected_out.push_back(ladder_step(samples.audio_sample, samples.cutoff,
                                                   samples.resonance));
            outstanding = expected_out.size();
        end
    end

endmodule

[tb/sv/tb.sv]
module tb;
    import rll_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic no_idle;
    logic hold_armed;
    logic hold_done;
    int   fail_count;
    int   pending;

    rll_in_if  samples_ch();
    rll_out_if results_ch();

    resonant_ladder_lowpass DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch)
    );

    ladder_checker u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_ch),
        .results     (results_ch),
        .mismatches  (fail_count),
        .outstanding (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1000000;
        $display("FAIL resonant_ladder_lowpass");
        $finish;
    end

    // receiver: random backpressure, one long hold-off
    initial
    begin
        hold_done = 1'b0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done)
            begin
                results_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                results_ch.ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] a,
                               input logic [SAMPLE_W-1:0] c,
                               input logic [SAMPLE_W-1:0] r);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.audio_sample <= a;
        samples_ch.cutoff       <= c;
        samples_ch.resonance    <= r;
        @(posedge clk);
        while (samples_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        int seg_len;
        logic [SAMPLE_W-1:0] seg_cut;
        logic [SAMPLE_W-1:0] seg_res;
        logic [SAMPLE_W-1:0] aud;
        rst_n = 1'b0;
        no_idle    <= 1'b0;
        hold_armed <= 1'b0;
        samples_ch.valid        <= 1'b0;
        samples_ch.audio_sample <= '0;
        samples_ch.cutoff       <= '0;
        samples_ch.resonance    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(12'd0, 12'd0, 12'd0);
        send_sample(12'd4095, 12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095, 12'd0);
        send_sample(12'd4095, 12'd4095, 12'd0);
        send_sample(12'd0, 12'd4095, 12'd0);
        send_sample(12'd0, 12'd4095, 12'd0);
        send_sample(12'd2048, 12'd2048, 12'd2048);
        send_sample(12'd4095, 12'd1, 12'd4095);
        send_sample(12'd0, 12'd1000, 12'd4095);
        // drive hard at full resonance to push the loop into runaway
        for (int i = 0; i < 8; i++)
            send_sample((i % 2) ? 12'd4095 : 12'd0, 12'd4095, 12'd4095);
        send_sample(12'd0, 12'd0, 12'd4095);
        send_sample(12'd4095, 12'd0, 12'd4095);
        // recover with no feedback
        for (int i = 0; i < 4; i++)
            send_sample(12'd2048, 12'd4095, 12'd0);

        n = 0;
        while (n < 450)
        begin
            seg_len = $urandom_range(40, 1);
            seg_cut = SAMPLE_W'($urandom_range(4095));
            seg_res = SAMPLE_W'(($urandom_range(99) < 75) ? $urandom_range(2500)
                                                           : $urandom_range(4095));
            for (int i = 0; i < seg_len && n < 450; i++)
            begin
                if (n == 120)
                    no_idle <= 1'b1;
                if (n == 220)
                    no_idle <= 1'b0;
                if (n == 300)
                    hold_armed <= 1'b1;
                if ($urandom_range(99) < 15)
                    send_sample(SAMPLE_W'($urandom_range(4095)),
                                SAMPLE_W'($urandom_range(4095)),
                                SAMPLE_W'($urandom_range(4095)));
                else
                begin
                    case ($urandom_range(2))
                        0: aud = SAMPLE_W'($urandom_range(4095));
                        1: aud = ((i / 4) % 2) ? 12'd3800 : 12'd300;
                        default: aud = SAMPLE_W'(2048 + $urandom_range(400) - 200);
                    endcase
                    send_sample(aud, seg_cut, seg_res);
                end
                n = n + 1;
            end
        end
        samples_ch.valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS resonant_ladder_lowpass");
        else
            $display("FAIL resonant_ladder_lowpass");
        $finish;
    end

endmodule
